### rtl/core/assoc_lookup_table_with_stats_assert.svh
// Assertion macros for the associative lookup table.
`ifndef ASSOC_LOOKUP_TABLE_WITH_STATS_ASSERT_SVH
`define ASSOC_LOOKUP_TABLE_WITH_STATS_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define ALT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lookup table assertion failed");

// Consequent holds in the cycle after the antecedent.
`define ALT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lookup table assertion failed");

`endif

### rtl/core/alt_pkg.sv
// Shared types and constants for the associative lookup table.
`timescale 1ns / 1ps
`default_nettype none

package alt_pkg;

  localparam int ENTRIES_DEF       = 256;
  localparam int PAYLOAD_WIDTH_DEF = 32;
  localparam int KEY_W             = 64;
  localparam int DATA_W            = 32;
  localparam int CNT_W             = 32;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EVAL,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] payload_in;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [DATA_W-1:0] payload_out;
    logic [CNT_W-1:0]  hit_count;
    logic [CNT_W-1:0]  miss_count;
  } rsp_t;

  // Memory port enables.
  typedef struct packed {
    logic key_we;
    logic key_re;
    logic pay_we;
    logic pay_re;
  } mem_cmd_t;

  // Compare unit control.
  typedef struct packed {
    logic init;
    logic vld;
  } scan_ctl_t;

  // Compare unit status.
  typedef struct packed {
    logic hit;
    logic empty;
  } scan_sts_t;

  // Counter events.
  typedef struct packed {
    logic hit;
    logic miss;
    logic clr;
  } evt_t;

endpackage

`default_nettype wire

### rtl/core/alt_store.sv
// Key and payload memories of the lookup table.
`timescale 1ns / 1ps
`default_nettype none

module alt_store import alt_pkg::*; #(
  parameter int ENTRIES       = ENTRIES_DEF,
  parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF,
  localparam int IdxW         = $clog2(ENTRIES)
) (
  input  wire logic                     clk_i,
  input  wire mem_cmd_t                 mem_i,
  input  wire logic [IdxW-1:0]          waddr_i,
  input  wire logic [KEY_W-1:0]         kwdata_i,
  input  wire logic [PAYLOAD_WIDTH-1:0] pwdata_i,
  input  wire logic [IdxW-1:0]          kraddr_i,
  input  wire logic [IdxW-1:0]          praddr_i,
  output logic      [KEY_W-1:0]         krdata_o,
  output logic      [PAYLOAD_WIDTH-1:0] prdata_o
);

  logic [KEY_W-1:0]         key_mem_q [ENTRIES];
  logic [PAYLOAD_WIDTH-1:0] pay_mem_q [ENTRIES];
  logic [KEY_W-1:0]         krdata_q;
  logic [PAYLOAD_WIDTH-1:0] prdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_i.key_we) begin
      key_mem_q[waddr_i] <= kwdata_i;
    end
    if (mem_i.key_re) begin
      krdata_q <= key_mem_q[kraddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_i.pay_we) begin
      pay_mem_q[waddr_i] <= pwdata_i;
    end
    if (mem_i.pay_re) begin
      prdata_q <= pay_mem_q[praddr_i];
    end
  end

  assign krdata_o = krdata_q;
  assign prdata_o = prdata_q;

endmodule

`default_nettype wire

### rtl/core/alt_match.sv
// Shared key compare unit: tracks the first matching and first empty slot.
`timescale 1ns / 1ps
`default_nettype none

module alt_match import alt_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  localparam int IdxW   = $clog2(ENTRIES)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire scan_ctl_t        ctl_i,
  input  wire logic [IdxW-1:0]  idx_i,
  input  wire logic [KEY_W-1:0] rkey_i,
  input  wire logic [KEY_W-1:0] key_i,
  output scan_sts_t             sts_o,
  output logic      [IdxW-1:0]  hit_idx_o,
  output logic      [IdxW-1:0]  emp_idx_o
);

  logic            hit_q, hit_d;
  logic            emp_q, emp_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  logic [IdxW-1:0] emp_idx_q, emp_idx_d;

  always_comb begin
    hit_d     = hit_q;
    emp_d     = emp_q;
    hit_idx_d = hit_idx_q;
    emp_idx_d = emp_idx_q;
    if (ctl_i.init) begin
      hit_d = 1'b0;
      emp_d = 1'b0;
    end else if (ctl_i.vld) begin
      // keep only the lowest index of each kind
      if (!hit_q && (rkey_i == key_i)) begin
        hit_d     = 1'b1;
        hit_idx_d = idx_i;
      end
      if (!emp_q && (rkey_i == '0)) begin
        emp_d     = 1'b1;
        emp_idx_d = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
      emp_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
      emp_q <= emp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q <= hit_idx_d;
    emp_idx_q <= emp_idx_d;
  end

  assign sts_o.hit   = hit_q;
  assign sts_o.empty = emp_q;
  assign hit_idx_o   = hit_idx_q;
  assign emp_idx_o   = emp_idx_q;

endmodule

`default_nettype wire

### rtl/core/alt_seq.sv
// Sequencer: clearing sweep, key scan, slot choice and result timing.
`timescale 1ns / 1ps
`default_nettype none

module alt_seq import alt_pkg::*; #(
  parameter int ENTRIES       = ENTRIES_DEF,
  parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF,
  localparam int IdxW         = $clog2(ENTRIES)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire req_t                     req_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic                          found_o,
  output evt_t                          evt_o,
  output mem_cmd_t                      mem_o,
  output logic      [IdxW-1:0]          waddr_o,
  output logic      [KEY_W-1:0]         kwdata_o,
  output logic      [PAYLOAD_WIDTH-1:0] pwdata_o,
  output logic      [IdxW-1:0]          kraddr_o,
  output logic      [KEY_W-1:0]         key_o,
  output scan_ctl_t                     ctl_o,
  output logic      [IdxW-1:0]          idx_o,
  input  wire scan_sts_t                sts_i,
  input  wire logic [IdxW-1:0]          hit_idx_i,
  input  wire logic [IdxW-1:0]          emp_idx_i
);

  localparam logic [IdxW-1:0] Last = IdxW'(ENTRIES - 1);

  state_e            state_q, state_d;
  logic [IdxW-1:0]   cnt_q, cnt_d;
  logic              rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]   rd_idx_q, rd_idx_d;
  logic              clr_rsp_q, clr_rsp_d;
  logic              found_q, found_d;
  logic [1:0]        op_q;
  logic [KEY_W-1:0]  key_q;
  logic [DATA_W-1:0] pay_q;
  logic              accept;
  logic              scan_op;
  logic [63:0]       pay_ext;

  assign accept  = start_i && (state_q == ST_IDLE);
  assign scan_op = ((req_i.opcode == OP_LOOKUP) || (req_i.opcode == OP_INSERT)) &&
                   (req_i.key != '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (cnt_q == Last) begin
          state_d = clr_rsp_q ? ST_RESP : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          if (scan_op) begin
            state_d = ST_SCAN;
          end else if (req_i.opcode == OP_CLEAR) begin
            state_d = ST_CLEAR;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_SCAN: begin
        if (cnt_q == Last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_EVAL;
      ST_EVAL:  state_d = ST_RESP;
      ST_RESP:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    cnt_d     = cnt_q;
    rd_vld_d  = 1'b0;
    rd_idx_d  = rd_idx_q;
    clr_rsp_d = clr_rsp_q;
    found_d   = found_q;
    mem_o     = '0;
    evt_o     = '0;
    waddr_o   = cnt_q;
    busy_o    = 1'b1;
    done_o    = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_o.key_we = 1'b1;
        cnt_d        = cnt_q + 1'b1;
      end
      ST_IDLE: begin
        busy_o = 1'b0;
        cnt_d  = '0;
        if (start_i) begin
          clr_rsp_d = (req_i.opcode == OP_CLEAR);
          found_d   = 1'b0;
          evt_o.clr = (req_i.opcode == OP_CLEAR);
        end
      end
      ST_SCAN: begin
        mem_o.key_re = 1'b1;
        rd_vld_d     = 1'b1;
        rd_idx_d     = cnt_q;
        cnt_d        = cnt_q + 1'b1;
      end
      ST_DRAIN: begin
        // last read data is compared this cycle
      end
      ST_EVAL: begin
        if (op_q == OP_LOOKUP) begin
          if (sts_i.hit) begin
            mem_o.pay_re = 1'b1;
            evt_o.hit    = 1'b1;
            found_d      = 1'b1;
          end else begin
            evt_o.miss = 1'b1;
          end
        end else begin
          // update the match, else take the first empty slot, else slot 0
          mem_o.key_we = 1'b1;
          mem_o.pay_we = 1'b1;
          if (sts_i.hit) begin
            waddr_o = hit_idx_i;
          end else if (sts_i.empty) begin
            waddr_o = emp_idx_i;
          end else begin
            waddr_o = '0;
          end
        end
      end
      ST_RESP: begin
        done_o = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      clr_rsp_q <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_vld_d;
      clr_rsp_q <= clr_rsp_d;
      found_q   <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    if (accept) begin
      op_q  <= req_i.opcode;
      key_q <= req_i.key;
      pay_q <= req_i.payload_in;
    end
  end

  assign pay_ext   = 64'(pay_q);
  assign pwdata_o  = pay_ext[PAYLOAD_WIDTH-1:0];
  assign kwdata_o  = (state_q == ST_CLEAR) ? '0 : key_q;
  assign kraddr_o  = cnt_q;
  assign key_o     = key_q;
  assign ctl_o.init = accept;
  assign ctl_o.vld  = rd_vld_q;
  assign idx_o     = rd_idx_q;
  assign found_o   = found_q;

endmodule

`default_nettype wire

### rtl/core/assoc_lookup_table_with_stats.sv
// Top level of the associative lookup table with hit and miss counters.
//
//   channel   dir  handshake              payload
//   request   in   start && !busy         req_i  (opcode, key, payload_in)
//   result    out  done_o, one cycle      rsp_o  (found, payload_out, hit_count, miss_count)
//
// Lookup and insert scan every key through one compare unit, one slot a cycle from
// the key memory read port.
// Clear sweeps the key memory one slot a cycle.
// A zero key or an unused opcode skips the scan and goes straight to the result.
// After reset the same sweep runs, and busy stays high until it ends.
// The receiver cannot stall: each result is shown for one cycle only.
`timescale 1ns / 1ps
`default_nettype none

module assoc_lookup_table_with_stats import alt_pkg::*; #(
  parameter int ENTRIES       = ENTRIES_DEF,
  parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  input  wire req_t req_i,
  output logic      busy,
  output logic      done_o,
  output rsp_t      rsp_o
);

  localparam int IdxW = $clog2(ENTRIES);

  mem_cmd_t                 mem;
  evt_t                     evt;
  scan_ctl_t                ctl;
  scan_sts_t                sts;
  logic [IdxW-1:0]          waddr;
  logic [IdxW-1:0]          kraddr;
  logic [IdxW-1:0]          idx;
  logic [IdxW-1:0]          hit_idx;
  logic [IdxW-1:0]          emp_idx;
  logic [KEY_W-1:0]         kwdata;
  logic [KEY_W-1:0]         krdata;
  logic [KEY_W-1:0]         key;
  logic [PAYLOAD_WIDTH-1:0] pwdata;
  logic [PAYLOAD_WIDTH-1:0] prdata;
  logic                     found;
  logic [63:0]              prd_ext;
  logic [CNT_W-1:0]         hits_q, hits_d;
  logic [CNT_W-1:0]         misses_q, misses_d;

  alt_seq #(
    .ENTRIES       (ENTRIES),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .req_i     (req_i),
    .busy_o    (busy),
    .done_o    (done_o),
    .found_o   (found),
    .evt_o     (evt),
    .mem_o     (mem),
    .waddr_o   (waddr),
    .kwdata_o  (kwdata),
    .pwdata_o  (pwdata),
    .kraddr_o  (kraddr),
    .key_o     (key),
    .ctl_o     (ctl),
    .idx_o     (idx),
    .sts_i     (sts),
    .hit_idx_i (hit_idx),
    .emp_idx_i (emp_idx)
  );

  alt_match #(
    .ENTRIES (ENTRIES)
  ) u_match (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .idx_i     (idx),
    .rkey_i    (krdata),
    .key_i     (key),
    .sts_o     (sts),
    .hit_idx_o (hit_idx),
    .emp_idx_o (emp_idx)
  );

  alt_store #(
    .ENTRIES       (ENTRIES),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_store (
    .clk_i    (clk_i),
    .mem_i    (mem),
    .waddr_i  (waddr),
    .kwdata_i (kwdata),
    .pwdata_i (pwdata),
    .kraddr_i (kraddr),
    .praddr_i (hit_idx),
    .krdata_o (krdata),
    .prdata_o (prdata)
  );

  // saturating statistics
  always_comb begin
    hits_d   = hits_q;
    misses_d = misses_q;
    if (evt.clr) begin
      hits_d   = '0;
      misses_d = '0;
    end else begin
      if (evt.hit && (hits_q != '1)) begin
        hits_d = hits_q + 1'b1;
      end
      if (evt.miss && (misses_q != '1)) begin
        misses_d = misses_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q   <= '0;
      misses_q <= '0;
    end else begin
      hits_q   <= hits_d;
      misses_q <= misses_d;
    end
  end

  assign prd_ext           = 64'(prdata);
  assign rsp_o.found       = found;
  assign rsp_o.payload_out = found ? prd_ext[DATA_W-1:0] : '0;
  assign rsp_o.hit_count   = hits_q;
  assign rsp_o.miss_count  = misses_q;

`include "assoc_lookup_table_with_stats_assert.svh"

  `ALT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `ALT_ASSERT_NEXT(a_done_frees, done_o, !busy)
  `ALT_ASSERT_NOW(a_hit_counted, done_o && rsp_o.found, rsp_o.hit_count != '0)
  `ALT_ASSERT_NOW(a_miss_zero_pay, done_o && !rsp_o.found, rsp_o.payload_out == '0)

endmodule

`default_nettype wire
